// File: hw/rtl/hcid_pkg.sv
// Package for the hybrid CPU instruction decoder: types, codes and opcode pattern table.
`timescale 1ns / 1ps

package hcid_pkg;

    // Table sizes, in priority order
    localparam int unsigned NUM_COMMON = 72;
    localparam int unsigned NUM_IO16   = 6;
    localparam int unsigned NUM_EMATH  = 15;
    localparam int unsigned NUM_EXTRA  = 2;
    localparam int unsigned NUM_ALL    = NUM_COMMON + NUM_IO16 + NUM_EMATH + NUM_EXTRA;

    localparam int unsigned FIRST_IO16  = NUM_COMMON;
    localparam int unsigned FIRST_EMATH = NUM_COMMON + NUM_IO16;
    localparam int unsigned FIRST_EXTRA = NUM_COMMON + NUM_IO16 + NUM_EMATH;

    localparam int unsigned IDX_W  = 7;
    localparam int unsigned WORD_W = 16;
    localparam int unsigned ADDR_W = 4;
    localparam int unsigned DATA_W = 32;

    // Address masks and page base
    localparam logic [WORD_W-1:0] PAGE_MASK  = 16'hfc00;
    localparam logic [WORD_W-1:0] PAGE_OFS   = 16'h0200;
    localparam logic [WORD_W-1:0] ADDR15_MSK = 16'h7fff;

    typedef enum logic [2:0] {
        K_NONE = 3'd0,
        K_LOC  = 3'd1,
        K_A32  = 3'd2,
        K_SKIP = 3'd3,
        K_SKSC = 3'd4,
        K_RET  = 3'd5,
        K_CNT  = 3'd6,
        K_REG  = 3'd7
    } t_kind;

    typedef enum logic [1:0] {
        S_PLAIN = 2'd0,
        S_COND  = 2'd1,
        S_CALL  = 2'd2,
        S_RET   = 2'd3
    } t_step;

    typedef enum logic [2:0] {
        MOD_NONE = 3'd0,
        MOD_S    = 3'd1,
        MOD_C    = 3'd2,
        MOD_P    = 3'd3,
        MOD_D    = 3'd4,
        MOD_I    = 3'd5
    } t_mod;

    // Register word index (paddr[3:2])
    typedef enum logic [1:0] {
        REG_ABS_PAGING = 2'd0,
        REG_ADDR15     = 2'd1,
        REG_EMATH      = 2'd2,
        REG_EXTRA      = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic abs_paging;
        logic addr15;
        logic emath;
        logic extra;
    } t_cfg;

    typedef struct packed {
        logic              found;
        logic [IDX_W-1:0]  index;
        t_kind             kind;
        t_step             step;
    } t_match;

    typedef struct packed {
        logic [WORD_W-1:0] value;
        logic              ind;
        t_mod              modif;
    } t_operand;

    typedef struct packed {
        logic [WORD_W-1:0] mask;
        logic [WORD_W-1:0] value;
        t_kind             kind;
        t_step             step;
    } t_pattern;

    localparam t_pattern PATTERNS [0:NUM_ALL-1] = '{
        // common
        '{16'hffff, 16'h0000, K_NONE, S_PLAIN},
        '{16'h7800, 16'h0000, K_LOC, S_PLAIN}, '{16'h7800, 16'h0800, K_LOC, S_PLAIN},
        '{16'h7800, 16'h1000, K_LOC, S_COND},  '{16'h7800, 16'h1800, K_LOC, S_COND},
        '{16'h7800, 16'h2000, K_LOC, S_PLAIN}, '{16'h7800, 16'h2800, K_LOC, S_PLAIN},
        '{16'h7800, 16'h3000, K_LOC, S_PLAIN}, '{16'h7800, 16'h3800, K_LOC, S_PLAIN},
        '{16'h7800, 16'h4000, K_LOC, S_CALL},  '{16'h7800, 16'h4800, K_LOC, S_COND},
        '{16'h7800, 16'h5000, K_LOC, S_PLAIN}, '{16'h7800, 16'h5800, K_LOC, S_COND},
        '{16'h7800, 16'h6000, K_LOC, S_PLAIN}, '{16'h7800, 16'h6800, K_LOC, S_PLAIN},
        '{16'h7fe0, 16'h7000, K_A32, S_PLAIN},
        '{16'hffc0, 16'h7400, K_SKIP, S_COND}, '{16'hffc0, 16'h7c00, K_SKIP, S_COND},
        '{16'hffc0, 16'h7440, K_SKIP, S_COND}, '{16'hffc0, 16'h7c40, K_SKIP, S_COND},
        '{16'hffc0, 16'h74c0, K_SKIP, S_COND}, '{16'hffc0, 16'h7500, K_SKIP, S_COND},
        '{16'hffc0, 16'h7d00, K_SKIP, S_COND}, '{16'hffc0, 16'h7540, K_SKIP, S_COND},
        '{16'hffc0, 16'h7d40, K_SKIP, S_COND}, '{16'hffc0, 16'h7480, K_SKIP, S_COND},
        '{16'hffc0, 16'h7580, K_SKIP, S_COND}, '{16'hffc0, 16'h75c0, K_SKIP, S_COND},
        '{16'hffc0, 16'h7c80, K_SKIP, S_COND}, '{16'hffc0, 16'h7d80, K_SKIP, S_COND},
        '{16'hffc0, 16'h7cc0, K_SKIP, S_COND}, '{16'hffc0, 16'h7dc0, K_SKIP, S_COND},
        '{16'hff00, 16'h7600, K_SKSC, S_COND}, '{16'hff00, 16'h7e00, K_SKSC, S_COND},
        '{16'hff00, 16'h7700, K_SKSC, S_COND}, '{16'hff00, 16'h7f00, K_SKSC, S_COND},
        '{16'hff00, 16'hf400, K_SKSC, S_COND}, '{16'hff00, 16'hfc00, K_SKSC, S_COND},
        '{16'hff00, 16'hf500, K_SKSC, S_COND}, '{16'hff00, 16'hfd00, K_SKSC, S_COND},
        '{16'hff00, 16'hf600, K_SKSC, S_COND}, '{16'hff00, 16'hf700, K_SKSC, S_COND},
        '{16'hff00, 16'hfe00, K_SKSC, S_COND}, '{16'hff00, 16'hff00, K_SKSC, S_COND},
        '{16'hffff, 16'hf020, K_NONE, S_PLAIN}, '{16'hffff, 16'hf820, K_NONE, S_PLAIN},
        '{16'hffff, 16'hf060, K_NONE, S_PLAIN}, '{16'hffff, 16'hf860, K_NONE, S_PLAIN},
        '{16'hff80, 16'hf080, K_RET, S_RET},
        '{16'hfff0, 16'hf100, K_CNT, S_PLAIN}, '{16'hfff0, 16'hf900, K_CNT, S_PLAIN},
        '{16'hffff, 16'hf14f, K_NONE, S_PLAIN}, '{16'hfff0, 16'hf140, K_CNT, S_PLAIN},
        '{16'hffff, 16'hf94f, K_NONE, S_PLAIN}, '{16'hfff0, 16'hf940, K_CNT, S_PLAIN},
        '{16'hfff0, 16'hf180, K_CNT, S_PLAIN}, '{16'hfff0, 16'hf980, K_CNT, S_PLAIN},
        '{16'hfff0, 16'hf1c0, K_CNT, S_PLAIN}, '{16'hfff0, 16'hf9c0, K_CNT, S_PLAIN},
        '{16'hffff, 16'h7110, K_NONE, S_PLAIN}, '{16'hffff, 16'h7118, K_NONE, S_PLAIN},
        '{16'hffff, 16'h7120, K_NONE, S_PLAIN}, '{16'hffff, 16'h7128, K_NONE, S_PLAIN},
        '{16'hffff, 16'h7138, K_NONE, S_PLAIN},
        '{16'hff78, 16'h7160, K_REG, S_PLAIN}, '{16'hff78, 16'h7168, K_REG, S_PLAIN},
        '{16'hff78, 16'h7960, K_REG, S_PLAIN}, '{16'hff78, 16'h7968, K_REG, S_PLAIN},
        '{16'hff78, 16'h7170, K_REG, S_PLAIN}, '{16'hff78, 16'h7178, K_REG, S_PLAIN},
        '{16'hff78, 16'h7970, K_REG, S_PLAIN}, '{16'hff78, 16'h7978, K_REG, S_PLAIN},
        // I/O-16
        '{16'hffff, 16'h7100, K_NONE, S_PLAIN}, '{16'hffff, 16'h7108, K_NONE, S_PLAIN},
        '{16'hffff, 16'h7140, K_NONE, S_PLAIN}, '{16'hffff, 16'h7148, K_NONE, S_PLAIN},
        '{16'hffff, 16'h7150, K_NONE, S_PLAIN}, '{16'hffff, 16'h7158, K_NONE, S_PLAIN},
        // extended math
        '{16'hffff, 16'h7200, K_NONE, S_PLAIN}, '{16'hffff, 16'h7220, K_NONE, S_PLAIN},
        '{16'hffff, 16'h7260, K_NONE, S_PLAIN}, '{16'hffff, 16'h7280, K_NONE, S_PLAIN},
        '{16'hfff0, 16'h7300, K_CNT, S_PLAIN},  '{16'hffff, 16'h7340, K_NONE, S_PLAIN},
        '{16'hfff0, 16'h7380, K_CNT, S_PLAIN},  '{16'hffff, 16'h73c0, K_NONE, S_PLAIN},
        '{16'hffff, 16'h7a00, K_NONE, S_PLAIN}, '{16'hffff, 16'h7a21, K_NONE, S_PLAIN},
        '{16'hffff, 16'h7b00, K_NONE, S_PLAIN}, '{16'hffff, 16'h7b21, K_NONE, S_PLAIN},
        '{16'hffff, 16'h7b40, K_NONE, S_PLAIN}, '{16'hffff, 16'h7b61, K_NONE, S_PLAIN},
        '{16'hffff, 16'h7b8f, K_NONE, S_PLAIN},
        // extra control
        '{16'hffff, 16'h7026, K_NONE, S_PLAIN}, '{16'hffff, 16'h7027, K_NONE, S_PLAIN}
    };

endpackage

// File: hw/rtl/hybrid_cpu_instruction_decoder.sv
// Top level of the hybrid CPU instruction decoder: input register, decode, result register, APB regs.
//
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+------------------------------------------------
//  input    | in        | i_valid / o_stall   | i_instruction_word, i_program_counter
//  result   | out       | o_valid / i_stall   | o_recognized .. o_step_class (7 fields)
//  config   | in        | psel/penable/pready | paddr, pwdata, prdata (4 one-bit registers)
//
//  One beat per cycle sustained while the output is not stalled; a beat is held in the input
//  register, then passes through table match and operand adders into the result register.
//  Reset clears the valid flags and all four config bits; no clearing pass is needed.
//  A stalled result holds the result register; the input register still takes one more beat,
//  so o_stall rises only when both stages are full and the output is stalled.
`timescale 1ns / 1ps

module hybrid_cpu_instruction_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [15:0] i_instruction_word,
    input  logic [15:0] i_program_counter,
    // result channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_recognized,
    output logic [6:0]  o_mnemonic_index,
    output logic [2:0]  o_operand_kind,
    output logic [15:0] o_operand_value,
    output logic        o_indirect_bit,
    output logic [2:0]  o_modifier,
    output logic [1:0]  o_step_class,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [hcid_pkg::ADDR_W-1:0] paddr,
    input  logic [hcid_pkg::DATA_W-1:0] pwdata,
    output logic [hcid_pkg::DATA_W-1:0] prdata,
    output logic        pready
);

    hcid_pkg::t_cfg     r_cfg;
    hcid_pkg::t_cfg     n_cfg;
    hcid_pkg::t_reg_idx w_reg_idx;
    logic               w_cfg_wr;

    logic               r_s1_valid;
    logic               n_s1_valid;
    logic [15:0]        r_s1_word;
    logic [15:0]        r_s1_pc;
    logic               r_s2_valid;
    logic               n_s2_valid;

    logic               w_s1_load;
    logic               w_s2_load;

    hcid_pkg::t_match   w_match;
    hcid_pkg::t_operand w_operand;

    logic               r_recognized;
    logic [6:0]         r_index;
    logic [2:0]         r_kind;
    logic [15:0]        r_value;
    logic               r_ind;
    logic [2:0]         r_mod;
    logic [1:0]         r_step;

    // Config register file
    assign pready    = 1'b1;
    assign w_reg_idx = hcid_pkg::t_reg_idx'(paddr[3:2]);
    assign w_cfg_wr  = psel & penable & pwrite & pready;

    always_comb begin
        n_cfg = r_cfg;
        if (w_cfg_wr) begin
            case (w_reg_idx)
                hcid_pkg::REG_ABS_PAGING: n_cfg.abs_paging = pwdata[0];
                hcid_pkg::REG_ADDR15:     n_cfg.addr15     = pwdata[0];
                hcid_pkg::REG_EMATH:      n_cfg.emath      = pwdata[0];
                hcid_pkg::REG_EXTRA:      n_cfg.extra      = pwdata[0];
                default:                  n_cfg            = r_cfg;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (w_reg_idx)
            hcid_pkg::REG_ABS_PAGING: prdata[0] = r_cfg.abs_paging;
            hcid_pkg::REG_ADDR15:     prdata[0] = r_cfg.addr15;
            hcid_pkg::REG_EMATH:      prdata[0] = r_cfg.emath;
            hcid_pkg::REG_EXTRA:      prdata[0] = r_cfg.extra;
            default:                  prdata    = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // Pipeline control: result register loads when empty or drained
    assign w_s2_load = r_s1_valid & (~r_s2_valid | ~i_stall);
    assign o_stall   = r_s1_valid & r_s2_valid & i_stall;
    assign w_s1_load = i_valid & ~o_stall;

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (w_s1_load) begin
            n_s1_valid = 1'b1;
        end else if (w_s2_load) begin
            n_s1_valid = 1'b0;
        end
        n_s2_valid = r_s2_valid;
        if (w_s2_load) begin
            n_s2_valid = 1'b1;
        end else if (!i_stall) begin
            n_s2_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
            r_s2_valid <= n_s2_valid;
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (w_s1_load) begin
            r_s1_word <= i_instruction_word;
            r_s1_pc   <= i_program_counter;
        end
    end

    // Decode
    hcid_match u_match (
        .i_word  (r_s1_word),
        .i_cfg   (r_cfg),
        .o_match (w_match)
    );

    hcid_operand u_operand (
        .i_word    (r_s1_word),
        .i_pc      (r_s1_pc),
        .i_kind    (w_match.kind),
        .i_cfg     (r_cfg),
        .o_operand (w_operand)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (w_s2_load) begin
            r_recognized <= w_match.found;
            r_index      <= w_match.index;
            r_kind       <= w_match.kind;
            r_value      <= w_operand.value;
            r_ind        <= w_operand.ind;
            r_mod        <= w_operand.modif;
            r_step       <= w_match.step;
        end
    end

    assign o_valid          = r_s2_valid;
    assign o_recognized     = r_recognized;
    assign o_mnemonic_index = r_index;
    assign o_operand_kind   = r_kind;
    assign o_operand_value  = r_value;
    assign o_indirect_bit   = r_ind;
    assign o_modifier       = r_mod;
    assign o_step_class     = r_step;

    // Checks
    a_unknown_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_recognized |-> o_mnemonic_index == '0 && o_operand_value == '0 &&
        o_operand_kind == hcid_pkg::K_NONE && o_modifier == hcid_pkg::MOD_NONE &&
        o_step_class == hcid_pkg::S_PLAIN && !o_indirect_bit)
        else $error("unknown opcode result not cleared");

    a_ind_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_indirect_bit |->
        o_operand_kind == hcid_pkg::K_LOC || o_operand_kind == hcid_pkg::K_A32)
        else $error("indirect bit on a kind without address");

    a_reg_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_operand_kind == hcid_pkg::K_REG |->
        o_modifier == hcid_pkg::MOD_D || o_modifier == hcid_pkg::MOD_I)
        else $error("register operand without D/I suffix");

    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s2_load |=> o_valid)
        else $error("decoded beat lost on the way to the result register");

endmodule

// File: hw/rtl/hcid_match.sv
// Priority opcode matcher: compares the word against every enabled pattern, lowest index wins.
`timescale 1ns / 1ps

module hcid_match (
    input  logic [hcid_pkg::WORD_W-1:0] i_word,
    input  hcid_pkg::t_cfg              i_cfg,
    output hcid_pkg::t_match            o_match
);

    logic [hcid_pkg::NUM_ALL-1:0] w_hit;

    // Per-entry compare, gated by the table enables
    always_comb begin
        for (int i = 0; i < hcid_pkg::NUM_ALL; i++) begin
            w_hit[i] = ((i_word & hcid_pkg::PATTERNS[i].mask) == hcid_pkg::PATTERNS[i].value);
            if (i >= hcid_pkg::FIRST_EXTRA) begin
                w_hit[i] = w_hit[i] & i_cfg.extra;
            end else if (i >= hcid_pkg::FIRST_EMATH) begin
                w_hit[i] = w_hit[i] & i_cfg.emath;
            end else if (i >= hcid_pkg::FIRST_IO16) begin
                w_hit[i] = w_hit[i] & ~i_cfg.addr15;
            end
        end
    end

    // Priority select: scan from the top so the lowest hit is left standing
    always_comb begin
        o_match.found = 1'b0;
        o_match.index = '0;
        o_match.kind  = hcid_pkg::K_NONE;
        o_match.step  = hcid_pkg::S_PLAIN;
        for (int i = hcid_pkg::NUM_ALL - 1; i >= 0; i--) begin
            if (w_hit[i]) begin
                o_match.found = 1'b1;
                o_match.index = i[hcid_pkg::IDX_W-1:0];
                o_match.kind  = hcid_pkg::PATTERNS[i].kind;
                o_match.step  = hcid_pkg::PATTERNS[i].step;
            end
        end
    end

endmodule

// File: hw/rtl/hcid_operand.sv
// Operand decode: effective address, skip target, count, register and suffix from the word.
`timescale 1ns / 1ps

module hcid_operand (
    input  logic [hcid_pkg::WORD_W-1:0] i_word,
    input  logic [hcid_pkg::WORD_W-1:0] i_pc,
    input  hcid_pkg::t_kind             i_kind,
    input  hcid_pkg::t_cfg              i_cfg,
    output hcid_pkg::t_operand          o_operand
);

    logic [hcid_pkg::WORD_W-1:0] w_ofs10;
    logic [hcid_pkg::WORD_W-1:0] w_ofs6;
    logic [hcid_pkg::WORD_W-1:0] w_base;
    logic [hcid_pkg::WORD_W-1:0] w_loc_sum;
    logic [hcid_pkg::WORD_W-1:0] w_skip_sum;
    logic [hcid_pkg::WORD_W-1:0] w_addr_mask;

    // Sign-extended offsets
    assign w_ofs10 = {{6{i_word[9]}}, i_word[9:0]};
    assign w_ofs6  = {{10{i_word[5]}}, i_word[5:0]};

    // Memory reference base: base page, or current page (absolute or pc-relative)
    always_comb begin
        if (!i_word[10]) begin
            w_base = '0;
        end else if (i_cfg.abs_paging) begin
            w_base = (i_pc & hcid_pkg::PAGE_MASK) | hcid_pkg::PAGE_OFS;
        end else begin
            w_base = i_pc;
        end
    end

    assign w_addr_mask = i_cfg.addr15 ? hcid_pkg::ADDR15_MSK : '1;
    assign w_loc_sum   = (w_base + w_ofs10) & w_addr_mask;
    assign w_skip_sum  = (i_pc + w_ofs6) & w_addr_mask;

    // Per-kind operand fields
    always_comb begin
        o_operand.value = '0;
        o_operand.ind   = 1'b0;
        o_operand.modif = hcid_pkg::MOD_NONE;
        case (i_kind)
            hcid_pkg::K_LOC: begin
                o_operand.value = w_loc_sum;
                o_operand.ind   = i_word[15];
            end
            hcid_pkg::K_A32: begin
                o_operand.value = {11'b0, i_word[4:0]};
                o_operand.ind   = i_word[15];
            end
            hcid_pkg::K_SKIP: begin
                o_operand.value = w_skip_sum;
            end
            hcid_pkg::K_SKSC: begin
                o_operand.value = w_skip_sum;
                if (i_word[7]) begin
                    o_operand.modif = i_word[6] ? hcid_pkg::MOD_S : hcid_pkg::MOD_C;
                end
            end
            hcid_pkg::K_RET: begin
                o_operand.value = w_ofs6;
                if (i_word[6]) begin
                    o_operand.modif = hcid_pkg::MOD_P;
                end
            end
            hcid_pkg::K_CNT: begin
                o_operand.value = {12'b0, i_word[3:0]} + 16'd1;
            end
            hcid_pkg::K_REG: begin
                o_operand.value = {13'b0, i_word[2:0]};
                o_operand.modif = i_word[7] ? hcid_pkg::MOD_D : hcid_pkg::MOD_I;
            end
            default: begin
                o_operand.value = '0;
            end
        endcase
    end

endmodule

// File: test/testbench.sv
// Self-checking testbench for the hybrid CPU instruction decoder.
`timescale 1ns / 1ps

module testbench;

    // One opcode table row: word & mask == bits selects the row
    typedef struct packed {
        logic [15:0]     mask;
        logic [15:0]     bits;
        hcid_pkg::t_kind kind;
        hcid_pkg::t_step step;
    } t_opcode;

    // One decoded instruction, as the result port carries it
    typedef struct packed {
        logic            recognized;
        logic [6:0]      index;
        hcid_pkg::t_kind kind;
        logic [15:0]     value;
        logic            ind;
        hcid_pkg::t_mod  modif;
        hcid_pkg::t_step step;
    } t_decode;

    // Opcode map in priority order: common, I/O-16, extended math, extra control
    localparam t_opcode OPCODE_MAP [0:94] = '{
        '{16'hffff, 16'h0000, hcid_pkg::K_NONE, hcid_pkg::S_PLAIN},
        '{16'h7800, 16'h0000, hcid_pkg::K_LOC, hcid_pkg::S_PLAIN},
        '{16'h7800, 16'h0800, hcid_pkg::K_LOC, hcid_pkg::S_PLAIN},
        '{16'h7800, 16'h1000, hcid_pkg::K_LOC, hcid_pkg::S_COND},
        '{16'h7800, 16'h1800, hcid_pkg::K_LOC, hcid_pkg::S_COND},
        '{16'h7800, 16'h2000, hcid_pkg::K_LOC, hcid_pkg::S_PLAIN},
        '{16'h7800, 16'h2800, hcid_pkg::K_LOC, hcid_pkg::S_PLAIN},
        '{16'h7800, 16'h3000, hcid_pkg::K_LOC, hcid_pkg::S_PLAIN},
        '{16'h7800, 16'h3800, hcid_pkg::K_LOC, hcid_pkg::S_PLAIN},
        '{16'h7800, 16'h4000, hcid_pkg::K_LOC, hcid_pkg::S_CALL},
        '{16'h7800, 16'h4800, hcid_pkg::K_LOC, hcid_pkg::S_COND},
        '{16'h7800, 16'h5000, hcid_pkg::K_LOC, hcid_pkg::S_PLAIN},
        '{16'h7800, 16'h5800, hcid_pkg::K_LOC, hcid_pkg::S_COND},
        '{16'h7800, 16'h6000, hcid_pkg::K_LOC, hcid_pkg::S_PLAIN},
        '{16'h7800, 16'h6800, hcid_pkg::K_LOC, hcid_pkg::S_PLAIN},
        '{16'h7fe0, 16'h7000, hcid_pkg::K_A32, hcid_pkg::S_PLAIN},
        '{16'hffc0, 16'h7400, hcid_pkg::K_SKIP, hcid_pkg::S_COND},
        '{16'hffc0, 16'h7c00, hcid_pkg::K_SKIP, hcid_pkg::S_COND},
        '{16'hffc0, 16'h7440, hcid_pkg::K_SKIP, hcid_pkg::S_COND},
        '{16'hffc0, 16'h7c40, hcid_pkg::K_SKIP, hcid_pkg::S_COND},
        '{16'hffc0, 16'h74c0, hcid_pkg::K_SKIP, hcid_pkg::S_COND},
        '{16'hffc0, 16'h7500, hcid_pkg::K_SKIP, hcid_pkg::S_COND},
        '{16'hffc0, 16'h7d00, hcid_pkg::K_SKIP, hcid_pkg::S_COND},
        '{16'hffc0, 16'h7540, hcid_pkg::K_SKIP, hcid_pkg::S_COND},
        '{16'hffc0, 16'h7d40, hcid_pkg::K_SKIP, hcid_pkg::S_COND},
        '{16'hffc0, 16'h7480, hcid_pkg::K_SKIP, hcid_pkg::S_COND},
        '{16'hffc0, 16'h7580, hcid_pkg::K_SKIP, hcid_pkg::S_COND},
        '{16'hffc0, 16'h75c0, hcid_pkg::K_SKIP, hcid_pkg::S_COND},
        '{16'hffc0, 16'h7c80, hcid_pkg::K_SKIP, hcid_pkg::S_COND},
        '{16'hffc0, 16'h7d80, hcid_pkg::K_SKIP, hcid_pkg::S_COND},
        '{16'hffc0, 16'h7cc0, hcid_pkg::K_SKIP, hcid_pkg::S_COND},
        '{16'hffc0, 16'h7dc0, hcid_pkg::K_SKIP, hcid_pkg::S_COND},
        '{16'hff00, 16'h7600, hcid_pkg::K_SKSC, hcid_pkg::S_COND},
        '{16'hff00, 16'h7e00, hcid_pkg::K_SKSC, hcid_pkg::S_COND},
        '{16'hff00, 16'h7700, hcid_pkg::K_SKSC, hcid_pkg::S_COND},
        '{16'hff00, 16'h7f00, hcid_pkg::K_SKSC, hcid_pkg::S_COND},
        '{16'hff00, 16'hf400, hcid_pkg::K_SKSC, hcid_pkg::S_COND},
        '{16'hff00, 16'hfc00, hcid_pkg::K_SKSC, hcid_pkg::S_COND},
        '{16'hff00, 16'hf500, hcid_pkg::K_SKSC, hcid_pkg::S_COND},
        '{16'hff00, 16'hfd00, hcid_pkg::K_SKSC, hcid_pkg::S_COND},
        '{16'hff00, 16'hf600, hcid_pkg::K_SKSC, hcid_pkg::S_COND},
        '{16'hff00, 16'hf700, hcid_pkg::K_SKSC, hcid_pkg::S_COND},
        '{16'hff00, 16'hfe00, hcid_pkg::K_SKSC, hcid_pkg::S_COND},
        '{16'hff00, 16'hff00, hcid_pkg::K_SKSC, hcid_pkg::S_COND},
        '{16'hffff, 16'hf020, hcid_pkg::K_NONE, hcid_pkg::S_PLAIN},
        '{16'hffff, 16'hf820, hcid_pkg::K_NONE, hcid_pkg::S_PLAIN},
        '{16'hffff, 16'hf060, hcid_pkg::K_NONE, hcid_pkg::S_PLAIN},
        '{16'hffff, 16'hf860, hcid_pkg::K_NONE, hcid_pkg::S_PLAIN},
        '{16'hff80, 16'hf080, hcid_pkg::K_RET, hcid_pkg::S_RET},
        '{16'hfff0, 16'hf100, hcid_pkg::K_CNT, hcid_pkg::S_PLAIN},
        '{16'hfff0, 16'hf900, hcid_pkg::K_CNT, hcid_pkg::S_PLAIN},
        '{16'hffff, 16'hf14f, hcid_pkg::K_NONE, hcid_pkg::S_PLAIN},
        '{16'hfff0, 16'hf140, hcid_pkg::K_CNT, hcid_pkg::S_PLAIN},
        '{16'hffff, 16'hf94f, hcid_pkg::K_NONE, hcid_pkg::S_PLAIN},
        '{16'hfff0, 16'hf940, hcid_pkg::K_CNT, hcid_pkg::S_PLAIN},
        '{16'hfff0, 16'hf180, hcid_pkg::K_CNT, hcid_pkg::S_PLAIN},
        '{16'hfff0, 16'hf980, hcid_pkg::K_CNT, hcid_pkg::S_PLAIN},
        '{16'hfff0, 16'hf1c0, hcid_pkg::K_CNT, hcid_pkg::S_PLAIN},
        '{16'hfff0, 16'hf9c0, hcid_pkg::K_CNT, hcid_pkg::S_PLAIN},
        '{16'hffff, 16'h7110, hcid_pkg::K_NONE, hcid_pkg::S_PLAIN},
        '{16'hffff, 16'h7118, hcid_pkg::K_NONE, hcid_pkg::S_PLAIN},
        '{16'hffff, 16'h7120, hcid_pkg::K_NONE, hcid_pkg::S_PLAIN},
        '{16'hffff, 16'h7128, hcid_pkg::K_NONE, hcid_pkg::S_PLAIN},
        '{16'hffff, 16'h7138, hcid_pkg::K_NONE, hcid_pkg::S_PLAIN},
        '{16'hff78, 16'h7160, hcid_pkg::K_REG, hcid_pkg::S_PLAIN},
        '{16'hff78, 16'h7168, hcid_pkg::K_REG, hcid_pkg::S_PLAIN},
        '{16'hff78, 16'h7960, hcid_pkg::K_REG, hcid_pkg::S_PLAIN},
        '{16'hff78, 16'h7968, hcid_pkg::K_REG, hcid_pkg::S_PLAIN},
        '{16'hff78, 16'h7170, hcid_pkg::K_REG, hcid_pkg::S_PLAIN},
        '{16'hff78, 16'h7178, hcid_pkg::K_REG, hcid_pkg::S_PLAIN},
        '{16'hff78, 16'h7970, hcid_pkg::K_REG, hcid_pkg::S_PLAIN},
        '{16'hff78, 16'h7978, hcid_pkg::K_REG, hcid_pkg::S_PLAIN},
        // I/O-16
        '{16'hffff, 16'h7100, hcid_pkg::K_NONE, hcid_pkg::S_PLAIN},
        '{16'hffff, 16'h7108, hcid_pkg::K_NONE, hcid_pkg::S_PLAIN},
        '{16'hffff, 16'h7140, hcid_pkg::K_NONE, hcid_pkg::S_PLAIN},
        '{16'hffff, 16'h7148, hcid_pkg::K_NONE, hcid_pkg::S_PLAIN},
        '{16'hffff, 16'h7150, hcid_pkg::K_NONE, hcid_pkg::S_PLAIN},
        '{16'hffff, 16'h7158, hcid_pkg::K_NONE, hcid_pkg::S_PLAIN},
        // extended math
        '{16'hffff, 16'h7200, hcid_pkg::K_NONE, hcid_pkg::S_PLAIN},
        '{16'hffff, 16'h7220, hcid_pkg::K_NONE, hcid_pkg::S_PLAIN},
        '{16'hffff, 16'h7260, hcid_pkg::K_NONE, hcid_pkg::S_PLAIN},
        '{16'hffff, 16'h7280, hcid_pkg::K_NONE, hcid_pkg::S_PLAIN},
        '{16'hfff0, 16'h7300, hcid_pkg::K_CNT, hcid_pkg::S_PLAIN},
        '{16'hffff, 16'h7340, hcid_pkg::K_NONE, hcid_pkg::S_PLAIN},
        '{16'hfff0, 16'h7380, hcid_pkg::K_CNT, hcid_pkg::S_PLAIN},
        '{16'hffff, 16'h73c0, hcid_pkg::K_NONE, hcid_pkg::S_PLAIN},
        '{16'hffff, 16'h7a00, hcid_pkg::K_NONE, hcid_pkg::S_PLAIN},
        '{16'hffff, 16'h7a21, hcid_pkg::K_NONE, hcid_pkg::S_PLAIN},
        '{16'hffff, 16'h7b00, hcid_pkg::K_NONE, hcid_pkg::S_PLAIN},
        '{16'hffff, 16'h7b21, hcid_pkg::K_NONE, hcid_pkg::S_PLAIN},
        '{16'hffff, 16'h7b40, hcid_pkg::K_NONE, hcid_pkg::S_PLAIN},
        '{16'hffff, 16'h7b61, hcid_pkg::K_NONE, hcid_pkg::S_PLAIN},
        '{16'hffff, 16'h7b8f, hcid_pkg::K_NONE, hcid_pkg::S_PLAIN},
        // extra control
        '{16'hffff, 16'h7026, hcid_pkg::K_NONE, hcid_pkg::S_PLAIN},
        '{16'hffff, 16'h7027, hcid_pkg::K_NONE, hcid_pkg::S_PLAIN}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [15:0] i_instruction_word;
    logic [15:0] i_program_counter;
    logic        o_valid;
    logic        i_stall;
    logic        o_recognized;
    logic [6:0]  o_mnemonic_index;
    logic [2:0]  o_operand_kind;
    logic [15:0] o_operand_value;
    logic        o_indirect_bit;
    logic [2:0]  o_modifier;
    logic [1:0]  o_step_class;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [hcid_pkg::ADDR_W-1:0] paddr;
    logic [hcid_pkg::DATA_W-1:0] pwdata;
    logic [hcid_pkg::DATA_W-1:0] prdata;
    logic        pready;

    // Mirror of the decoder's mode bits
    logic cfg_abs_paging;
    logic cfg_addr15;
    logic cfg_emath;
    logic cfg_extra;

    t_decode pending_decodes [$];
    int      mismatches = 0;
    int      send_idle_pct = 0;
    int      recv_stall_pct = 0;
    int      hold_left = 0;

    hybrid_cpu_instruction_decoder dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_instruction_word (i_instruction_word),
        .i_program_counter  (i_program_counter),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_recognized       (o_recognized),
        .o_mnemonic_index   (o_mnemonic_index),
        .o_operand_kind     (o_operand_kind),
        .o_operand_value    (o_operand_value),
        .o_indirect_bit     (o_indirect_bit),
        .o_modifier         (o_modifier),
        .o_step_class       (o_step_class),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        if (mismatches <= 40) begin
            $display("mismatch %s: got %0h, want %0h at %0t", what, got, want, $time);
        end
    endtask

    // Expected decode of one word under the current mode bits
    function automatic t_decode decode_word(input logic [15:0] w, input logic [15:0] pc);
        t_decode     r;
        int          hit;
        logic [15:0] base;
        logic [15:0] off;
        logic [15:0] addr;
        r   = '0;
        hit = -1;
        for (int i = 0; i < int'(hcid_pkg::NUM_ALL); i++) begin
            if (i >= int'(hcid_pkg::FIRST_IO16) && i < int'(hcid_pkg::FIRST_EMATH) &&
                cfg_addr15) continue;
            if (i >= int'(hcid_pkg::FIRST_EMATH) && i < int'(hcid_pkg::FIRST_EXTRA) &&
                !cfg_emath) continue;
            if (i >= int'(hcid_pkg::FIRST_EXTRA) && !cfg_extra) continue;
            if ((w & OPCODE_MAP[i].mask) == OPCODE_MAP[i].bits) begin
                hit = i;
                break;
            end
        end
        if (hit < 0) return r;
        r.recognized = 1'b1;
        r.index      = 7'(hit);
        r.kind       = OPCODE_MAP[hit].kind;
        r.step       = OPCODE_MAP[hit].step;
        case (r.kind)
            hcid_pkg::K_LOC: begin
                // bit 10 picks current page over base page
                if (!w[10]) base = 16'h0000;
                else if (cfg_abs_paging) base = (pc & 16'hfc00) | 16'h0200;
                else base = pc;
                off  = {{6{w[9]}}, w[9:0]};
                addr = base + off;
                r.value = cfg_addr15 ? (addr & 16'h7fff) : addr;
                r.ind   = w[15];
            end
            hcid_pkg::K_A32: begin
                r.value = {11'd0, w[4:0]};
                r.ind   = w[15];
            end
            hcid_pkg::K_SKIP, hcid_pkg::K_SKSC: begin
                off  = {{10{w[5]}}, w[5:0]};
                addr = pc + off;
                r.value = cfg_addr15 ? (addr & 16'h7fff) : addr;
                if (r.kind == hcid_pkg::K_SKSC && w[7])
                    r.modif = w[6] ? hcid_pkg::MOD_S : hcid_pkg::MOD_C;
            end
            hcid_pkg::K_RET: begin
                r.value = {{10{w[5]}}, w[5:0]};
                if (w[6]) r.modif = hcid_pkg::MOD_P;
            end
            hcid_pkg::K_CNT: r.value = {12'd0, w[3:0]} + 16'd1;
            hcid_pkg::K_REG: begin
                r.value = {13'd0, w[2:0]};
                r.modif = w[7] ? hcid_pkg::MOD_D : hcid_pkg::MOD_I;
            end
            default: ;
        endcase
        return r;
    endfunction

    // Offer one instruction beat; returns after it is taken. Called just after a falling edge.
    task automatic send_word(input logic [15:0] w, input logic [15:0] pc);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid            <= 1'b1;
        i_instruction_word <= w;
        i_program_counter  <= pc;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        pending_decodes.push_back(decode_word(w, pc));
        @(negedge i_clk);
    endtask

    // APB read: setup, then access, then the bus goes idle
    task automatic read_reg(input hcid_pkg::t_reg_idx idx,
                            output logic [hcid_pkg::DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        data = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    // APB write followed by a read-back
    task automatic write_reg(input hcid_pkg::t_reg_idx idx, input logic v);
        logic [hcid_pkg::DATA_W-1:0] rd;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {31'd0, v};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        case (idx)
            hcid_pkg::REG_ABS_PAGING: cfg_abs_paging = v;
            hcid_pkg::REG_ADDR15:     cfg_addr15 = v;
            hcid_pkg::REG_EMATH:      cfg_emath = v;
            hcid_pkg::REG_EXTRA:      cfg_extra = v;
            default: ;
        endcase
        @(negedge i_clk);
        read_reg(idx, rd);
        if (rd !== {31'd0, v}) report_mismatch("register read-back", rd, {31'd0, v});
    endtask

    // Wait until every decode has come out, then rewrite all mode bits
    task automatic apply_config(input logic [3:0] c);
        i_valid <= 1'b0;
        while (pending_decodes.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        write_reg(hcid_pkg::REG_ABS_PAGING, c[3]);
        write_reg(hcid_pkg::REG_ADDR15, c[2]);
        write_reg(hcid_pkg::REG_EMATH, c[1]);
        write_reg(hcid_pkg::REG_EXTRA, c[0]);
    endtask

    // Random beat: mostly a word shaped after some table row, sometimes raw noise
    task automatic send_random_word();
        int          row;
        logic [15:0] w;
        logic [15:0] pc;
        row = $urandom_range(94);
        w   = 16'($urandom);
        if ($urandom_range(99) < 85) w = (w & ~OPCODE_MAP[row].mask) | OPCODE_MAP[row].bits;
        case ($urandom_range(7))
            0:       pc = 16'($urandom_range(15));
            1:       pc = 16'hffff - 16'($urandom_range(15));
            2:       pc = 16'h7ff0 + 16'($urandom_range(31));
            default: pc = 16'($urandom);
        endcase
        send_word(w, pc);
    endtask

    // Receiver: random stalls, or a forced hold-off when one is requested
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_stall <= 1'b1;
            hold_left--;
        end else begin
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Result checker
    always @(posedge i_clk) begin : check_results
        t_decode got;
        t_decode want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_stall === 1'b0) begin
            got.recognized = o_recognized;
            got.index      = o_mnemonic_index;
            got.kind       = hcid_pkg::t_kind'(o_operand_kind);
            got.value      = o_operand_value;
            got.ind        = o_indirect_bit;
            got.modif      = hcid_pkg::t_mod'(o_modifier);
            got.step       = hcid_pkg::t_step'(o_step_class);
            if (pending_decodes.size() == 0) begin
                report_mismatch("beat with nothing pending", 32'(got.index), 32'd0);
            end else begin
                want = pending_decodes.pop_front();
                if (got.recognized !== want.recognized)
                    report_mismatch("recognized", 32'(got.recognized), 32'(want.recognized));
                if (got.index !== want.index)
                    report_mismatch("mnemonic_index", 32'(got.index), 32'(want.index));
                if (got.kind !== want.kind)
                    report_mismatch("operand_kind", 32'(got.kind), 32'(want.kind));
                if (got.value !== want.value)
                    report_mismatch("operand_value", 32'(got.value), 32'(want.value));
                if (got.ind !== want.ind)
                    report_mismatch("indirect_bit", 32'(got.ind), 32'(want.ind));
                if (got.modif !== want.modif)
                    report_mismatch("modifier", 32'(got.modif), 32'(want.modif));
                if (got.step !== want.step)
                    report_mismatch("step_class", 32'(got.step), 32'(want.step));
            end
        end
    end

    // All mode bits read back as zero out of reset
    task automatic test_register_reset();
        logic [hcid_pkg::DATA_W-1:0] rd;
        for (int i = 0; i < 4; i++) begin
            read_reg(hcid_pkg::t_reg_idx'(i), rd);
            if (rd !== '0) report_mismatch("register after reset", rd, 32'd0);
        end
    endtask

    // Hand-picked corner cases under default and fully enabled modes
    task automatic test_directed_cases();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_word(16'h0000, 16'h0000);  // all-zero word
        send_word(16'hffff, 16'hffff);  // all-ones word and address
        send_word(16'h0600, 16'h0100);  // current page, negative offset wraps below zero
        send_word(16'h83ff, 16'h1234);  // base page, offset -1, indirect
        send_word(16'h4dff, 16'hfff0);  // conditional, current page, wraps past top
        send_word(16'hf01f, 16'h0000);  // addr32, indirect
        send_word(16'h7420, 16'h0000);  // skip back past zero
        send_word(16'h741f, 16'hfff0);  // skip forward past top
        send_word(16'h76c0, 16'h8000);  // skip with set
        send_word(16'h7e80, 16'h0040);  // skip with clear
        send_word(16'h7740, 16'h0000);  // skip, no suffix
        send_word(16'hf0e0, 16'h0000);  // return -32 with pop
        send_word(16'hf09f, 16'h0000);  // return +31
        send_word(16'hf10f, 16'h0000);  // count 16
        send_word(16'hf14f, 16'h0000);  // fixed word ahead of a count row
        send_word(16'h71e7, 16'h0000);  // register, decrement
        send_word(16'h7160, 16'h0000);  // register, increment
        send_word(16'h7100, 16'h0000);  // I/O-16 enabled
        send_word(16'h7026, 16'h0000);  // extra control disabled
        send_word(16'h7b8f, 16'h0000);  // extended math disabled
        apply_config(4'b1111);
        send_word(16'h7100, 16'h0000);  // I/O-16 off in 15-bit mode
        send_word(16'h7027, 16'h0000);
        send_word(16'h7b8f, 16'h0000);
        send_word(16'h730f, 16'h0000);  // extended math count
        send_word(16'h0600, 16'hfdff);  // absolute paging
        send_word(16'h83ff, 16'h1234);  // -1 masked to 15 bits
        send_word(16'h741f, 16'hfff0);  // skip wrap then mask
    endtask

    // Random decode phases over idle profiles and mode settings
    task automatic test_random_decode();
        logic [3:0] modes [6];
        modes = '{4'b0000, 4'b1111, 4'b1010, 4'b0101, 4'($urandom), 4'($urandom)};
        for (int ph = 0; ph < 6; ph++) begin
            apply_config(modes[ph]);
            case (ph / 2)
                0: begin send_idle_pct = 14; recv_stall_pct = 76; end
                1: begin send_idle_pct = 76; recv_stall_pct = 14; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            repeat (200) send_random_word();
        end
    endtask

    // Long receiver hold-off while the sender keeps offering beats
    task automatic test_backpressure();
        apply_config(4'($urandom));
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        @(posedge i_clk);
        hold_left = 60;
        @(negedge i_clk);
        repeat (30) send_random_word();
    endtask

    initial begin
        i_rst_n            = 1'b0;
        i_valid            = 1'b0;
        i_instruction_word = '0;
        i_program_counter  = '0;
        i_stall            = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        cfg_abs_paging     = 1'b0;
        cfg_addr15         = 1'b0;
        cfg_emath          = 1'b0;
        cfg_extra          = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_register_reset();
        test_directed_cases();
        test_random_decode();
        test_backpressure();

        // drain
        i_valid <= 1'b0;
        while (pending_decodes.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Run limit
    initial begin
        #3_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
